### design/apq_pkg.sv
// Shared constants and types for the array priority queue.
// No dependencies; used by apq_scan and array_priority_queue_core.
package apq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 7;
  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int ENT_W  = VAL_W + PRI_W;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // control from the sequencer to the max-scan unit
  typedef struct packed {
    logic vld;    // read data on the RAM output belongs to the scan
    logic first;  // entry 0: seeds the running maximum
  } scan_ctl_t;

  // running best entry
  typedef struct packed {
    logic [ADDR_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
    logic [PRI_W-1:0]        pri;
  } best_t;

endpackage

### design/apq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/apq_scan.sv
// Max-priority scan unit: keeps the earliest entry holding the largest priority.
// Depends on apq_pkg.
module apq_scan (
  input  logic                          clk,
  input  apq_pkg::scan_ctl_t            ctl,
  input  logic [apq_pkg::ADDR_W-1:0]    idx,
  input  logic [apq_pkg::ENT_W-1:0]     entry,
  output apq_pkg::best_t                best
);

  logic [apq_pkg::PRI_W-1:0] pri;

  assign pri = entry[apq_pkg::PRI_W-1:0];

  // strict compare keeps the earlier entry on a tie
  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || (pri > best.pri))) begin
      best.idx <= idx;
      best.val <= entry[apq_pkg::ENT_W-1:apq_pkg::PRI_W];
      best.pri <= pri;
    end
  end

endmodule

### design/array_priority_queue_core.sv
// Top level of the array priority queue: sequencer, entry RAM and scan unit.
// Depends on apq_pkg, apq_ram and apq_scan.
//
// Usage
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low; kind, value and priority_req are sampled there.
//   Result channel: done is high for exactly one cycle and qualifies status,
//   out_value, out_priority and occupancy. There is no back-pressure; the
//   result is registered, so the next command may be issued in the cycle
//   where done is high.
// Operation (N = entries held, b = index of the selected entry)
//   insert, overflow, underflow, unused kind: result in the cycle after the
//     transfer, busy never rises.
//   peek: the N entries are read once, one per cycle, through
//     the RAM's registered read port while the scan unit tracks the maximum.
//   remove: the same scan, then, when entries above b must be moved down,
//     a shift pass over them (one read and one write-back per cycle).
// Reset: rst (synchronous) empties the queue; the RAM is not cleared since
//   only entries below the count are ever read.
// Entries live in one RAM word each, {value, priority}.
module array_priority_queue_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind,
  input  logic signed [apq_pkg::VAL_W-1:0]  value,
  input  logic [apq_pkg::PRI_W-1:0]         priority_req,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [apq_pkg::VAL_W-1:0]  out_value,
  output logic [apq_pkg::PRI_W-1:0]         out_priority,
  output logic [apq_pkg::OCC_W-1:0]         occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT
  } state_t;

  state_t                      state;
  logic [apq_pkg::CNT_W-1:0]   count;
  logic [1:0]                  kind_q;
  logic [apq_pkg::CNT_W-1:0]   issue_idx;
  logic                        data_vld;
  logic [apq_pkg::CNT_W-1:0]   data_idx;

  logic                        accept;
  logic [apq_pkg::CNT_W-1:0]   last_idx;
  logic                        last_data;
  logic [apq_pkg::CNT_W-1:0]   best_idx_w;

  logic                        wr_en;
  logic [apq_pkg::ADDR_W-1:0]  wr_addr;
  logic [apq_pkg::ENT_W-1:0]   wr_data;
  logic                        rd_en;
  logic [apq_pkg::ENT_W-1:0]   rd_data;

  apq_pkg::scan_ctl_t          scan_ctl;
  apq_pkg::best_t              best;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign last_idx   = count - apq_pkg::CNT_W'(1);
  assign last_data  = data_vld && (data_idx == last_idx);
  assign best_idx_w = apq_pkg::CNT_W'(best.idx);

  // reads stream out one per cycle while scanning or moving entries down
  assign rd_en = ((state == S_SCAN) || (state == S_SHIFT)) && (issue_idx < count);

  // write port: append on insert, or move the entry just read down one slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[apq_pkg::ADDR_W-1:0];
    wr_data = {value, priority_req};
    if (state == S_SHIFT) begin
      wr_en   = data_vld;
      wr_addr = apq_pkg::ADDR_W'(data_idx - apq_pkg::CNT_W'(1));
      wr_data = rd_data;
    end else if (accept && (kind == apq_pkg::KIND_INSERT)) begin
      wr_en = (count != apq_pkg::CNT_W'(apq_pkg::DEPTH));
    end
  end

  assign scan_ctl.vld   = (state == S_SCAN) && data_vld;
  assign scan_ctl.first = (data_idx == '0);

  apq_ram #(
    .WIDTH (apq_pkg::ENT_W),
    .DEPTH (apq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[apq_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  apq_scan u_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .idx   (data_idx[apq_pkg::ADDR_W-1:0]),
    .entry (rd_data),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      done     <= 1'b0;
      data_vld <= 1'b0;
    end else begin
      done     <= 1'b0;
      data_vld <= rd_en;
      data_idx <= issue_idx;
      if (rd_en) begin
        issue_idx <= issue_idx + apq_pkg::CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q       <= kind;
            out_value    <= '0;
            out_priority <= '0;
            occupancy    <= apq_pkg::OCC_W'(count);
            status       <= apq_pkg::ST_OK;
            unique case (kind)
              apq_pkg::KIND_INSERT: begin
                done <= 1'b1;
                if (count == apq_pkg::CNT_W'(apq_pkg::DEPTH)) begin
                  status <= apq_pkg::ST_OVERFLOW;
                end else begin
                  count     <= count + apq_pkg::CNT_W'(1);
                  occupancy <= apq_pkg::OCC_W'(count + apq_pkg::CNT_W'(1));
                end
              end
              apq_pkg::KIND_REMOVE, apq_pkg::KIND_PEEK: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= apq_pkg::ST_UNDERFLOW;
                end else begin
                  state     <= S_SCAN;
                  issue_idx <= '0;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (last_data) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // scan result is settled here
          out_value    <= best.val;
          out_priority <= best.pri;
          status       <= apq_pkg::ST_OK;
          if (kind_q == apq_pkg::KIND_PEEK) begin
            done      <= 1'b1;
            occupancy <= apq_pkg::OCC_W'(count);
            state     <= S_IDLE;
          end else if (best_idx_w == last_idx) begin
            // last entry selected: nothing to move
            done      <= 1'b1;
            count     <= last_idx;
            occupancy <= apq_pkg::OCC_W'(last_idx);
            state     <= S_IDLE;
          end else begin
            issue_idx <= best_idx_w + apq_pkg::CNT_W'(1);
            state     <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (last_data) begin
            done      <= 1'b1;
            count     <= last_idx;
            occupancy <= apq_pkg::OCC_W'(last_idx);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= apq_pkg::CNT_W'(apq_pkg::DEPTH))
    else $error("entry count above depth");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(busy)))
    else $error("result without a command in flight");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == apq_pkg::ST_UNDERFLOW)) |-> (occupancy == '0))
    else $error("underflow reported with entries held");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && (status == apq_pkg::ST_OVERFLOW)) |->
      (occupancy == apq_pkg::OCC_W'(apq_pkg::DEPTH)))
    else $error("overflow reported while not full");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != apq_pkg::ST_OK)) |-> ((out_value == '0) && (out_priority == '0)))
    else $error("error result carries data");
`endif

endmodule

### dv/tb_array_priority_queue_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for array_priority_queue_core: directed and random
// insert/remove/peek commands, checked against a queue-based model of the store.
// Depends on apq_pkg and the array_priority_queue_core RTL.
module tb_array_priority_queue_core;

  // kind 3 decodes to no operation
  localparam logic [1:0] KIND_NOP = 2'd3;

  // cycles with neither a command nor a result transfer before giving up;
  // a full-depth remove stays well within it, sender idle runs are short
  localparam int unsigned STALL_LIMIT = 2000;
  // settle time after the last result, about one worst-case remove
  localparam int unsigned TAIL_CYCLES = 2 * apq_pkg::DEPTH + 8;

  typedef struct {
    logic signed [apq_pkg::VAL_W-1:0] val;
    logic [apq_pkg::PRI_W-1:0]        pri;
  } entry_t;

  typedef struct {
    logic [1:0]                       status;
    logic signed [apq_pkg::VAL_W-1:0] val;
    logic [apq_pkg::PRI_W-1:0]        pri;
    logic [apq_pkg::OCC_W-1:0]        occ;
  } response_t;

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

  // Mirrors the queue contents in arrival order and keeps the responses
  // still owed by the block.
  class queue_tracker;
    entry_t      held[$];
    response_t   pending_responses[$];
    int unsigned mismatches;

    function int unsigned count();
      return held.size();
    endfunction

    function int unsigned pending();
      return pending_responses.size();
    endfunction

    // apply one accepted command to the model and queue its response
    function void note_command(input logic [1:0] k,
                               input logic signed [apq_pkg::VAL_W-1:0] v,
                               input logic [apq_pkg::PRI_W-1:0] p);
      response_t r;
      entry_t    e;
      int        best;
      r.status = apq_pkg::ST_OK;
      r.val    = '0;
      r.pri    = '0;
      case (k)
        apq_pkg::KIND_INSERT: begin
          if (held.size() >= apq_pkg::DEPTH) begin
            r.status = apq_pkg::ST_OVERFLOW;
          end else begin
            e.val = v;
            e.pri = p;
            held.push_back(e);
          end
        end
        apq_pkg::KIND_REMOVE, apq_pkg::KIND_PEEK: begin
          if (held.size() == 0) begin
            r.status = apq_pkg::ST_UNDERFLOW;
          end else begin
            // strict compare keeps the earliest entry on a tie
            best = 0;
            for (int i = 1; i < held.size(); i++) begin
              if (held[i].pri > held[best].pri) best = i;
            end
            r.val = held[best].val;
            r.pri = held[best].pri;
            if (k == apq_pkg::KIND_REMOVE) held.delete(best);
          end
        end
        default: ;
      endcase
      r.occ = apq_pkg::OCC_W'(held.size());
      pending_responses.push_back(r);
    endfunction

    function void check_response(input logic [1:0] st,
                                 input logic signed [apq_pkg::VAL_W-1:0] v,
                                 input logic [apq_pkg::PRI_W-1:0] p,
                                 input logic [apq_pkg::OCC_W-1:0] occ);
      response_t exp;
      if (pending_responses.size() == 0) begin
        $error("result with no command outstanding");
        mismatches++;
        return;
      end
      exp = pending_responses.pop_front();
      if (st !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, st);
        mismatches++;
      end
      if (v !== exp.val) begin
        $error("out_value: expected %0d, got %0d", exp.val, v);
        mismatches++;
      end
      if (p !== exp.pri) begin
        $error("out_priority: expected %0d, got %0d", exp.pri, p);
        mismatches++;
      end
      if (occ !== exp.occ) begin
        $error("occupancy: expected %0d, got %0d", exp.occ, occ);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [1:0]                       kind = apq_pkg::KIND_INSERT;
  logic signed [apq_pkg::VAL_W-1:0] value = '0;
  logic [apq_pkg::PRI_W-1:0]        priority_req = '0;
  logic                             done;
  logic [1:0]                       status;
  logic signed [apq_pkg::VAL_W-1:0] out_value;
  logic [apq_pkg::PRI_W-1:0]        out_priority;
  logic [apq_pkg::OCC_W-1:0]        occupancy;

  queue_tracker tracker = new();

  int unsigned idle_pct = 0;     // chance in 100 that the sender idles in a cycle
  bit          drain_next = 1'b0; // next command waits for all results
  int unsigned stall_cycles = 0;

  array_priority_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .priority_req (priority_req),
    .done         (done),
    .status       (status),
    .out_value    (out_value),
    .out_priority (out_priority),
    .occupancy    (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: done is a one-cycle strobe with no back-pressure
  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(status, out_value, out_priority, occupancy);
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // values: extremes now and then, otherwise any 32-bit pattern
  function automatic logic signed [apq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // priorities: narrow ranges give many ties, zero checks the all-zero scan
  function automatic logic [apq_pkg::PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return apq_pkg::PRI_W'($urandom_range(0, 3));
      2:       return apq_pkg::PRI_W'(16'hffff - $urandom_range(0, 3));
      default: return apq_pkg::PRI_W'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // Drive one command from a falling edge and hold it until the transfer.
  // start toggles at most once per edge: when the sender idles it drops here
  // and rises again at a later falling edge.
  task automatic send_command(input logic [1:0] k,
                              input logic signed [apq_pkg::VAL_W-1:0] v,
                              input logic [apq_pkg::PRI_W-1:0] p);
    bit drain;
    @(negedge clk);
    drain = drain_next || ($urandom_range(0, 63) == 0);
    drain_next = 1'b0;
    if (drain || ($urandom_range(0, 99) < idle_pct)) begin
      start <= 1'b0;
      do @(negedge clk);
      while ((drain && tracker.pending() > 0) || ($urandom_range(0, 99) < idle_pct));
    end
    kind         <= k;
    value        <= v;
    priority_req <= p;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_command(k, v, p);
  endtask

  // Random traffic in bursts. Fill bursts run into overflow, drain bursts
  // empty the store and poke underflow, mixed bursts are the noise.
  task automatic run_random(input int unsigned n_items, input bit fill_first);
    int unsigned issued;
    int unsigned burst;
    int unsigned r;
    burst_t      mode;
    logic [1:0]  k;
    issued = 0;
    while (issued < n_items) begin
      if (fill_first && issued == 0) begin
        mode = BURST_FILL;
      end else begin
        case ($urandom_range(0, 3))
          0:       mode = BURST_FILL;
          1:       mode = BURST_DRAIN;
          default: mode = BURST_MIXED;
        endcase
      end
      case (mode)
        BURST_FILL:  burst = apq_pkg::DEPTH - tracker.count() + $urandom_range(1, 3);
        BURST_DRAIN: burst = tracker.count() + tracker.count() / 4 + $urandom_range(1, 3);
        default:     burst = $urandom_range(10, 40);
      endcase
      if (burst > n_items - issued) burst = n_items - issued;
      repeat (burst) begin
        r = $urandom_range(0, 99);
        case (mode)
          BURST_FILL:  k = (r < 95) ? apq_pkg::KIND_INSERT : apq_pkg::KIND_PEEK;
          BURST_DRAIN: k = (r < 80) ? apq_pkg::KIND_REMOVE :
                           (r < 95) ? apq_pkg::KIND_PEEK : KIND_NOP;
          default:     k = (r < 40) ? apq_pkg::KIND_INSERT :
                           (r < 70) ? apq_pkg::KIND_REMOVE :
                           (r < 90) ? apq_pkg::KIND_PEEK : KIND_NOP;
        endcase
        send_command(k, pick_value(), pick_priority());
        issued++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty store, all-zero priorities, ties, middle and last removes
    idle_pct = 33;
    send_command(apq_pkg::KIND_REMOVE, 32'sd5, 16'h1234);       // underflow
    send_command(apq_pkg::KIND_PEEK, 32'sd6, 16'h4321);         // underflow
    send_command(KIND_NOP, 32'sh7fff_ffff, 16'hffff);           // no-op on empty store
    send_command(apq_pkg::KIND_INSERT, 32'sh7fff_ffff, 16'h0000);
    send_command(apq_pkg::KIND_INSERT, 32'sh8000_0000, 16'h0000);
    send_command(apq_pkg::KIND_PEEK, '0, '0);                   // all zero: earliest wins
    send_command(apq_pkg::KIND_INSERT, -32'sd1, 16'hffff);
    send_command(apq_pkg::KIND_INSERT, 32'sd0, 16'hffff);       // tie with the entry before
    send_command(apq_pkg::KIND_INSERT, 32'sd1, 16'h0001);
    send_command(apq_pkg::KIND_PEEK, '0, '0);
    send_command(apq_pkg::KIND_REMOVE, '0, '0);                 // middle entry, shift down
    send_command(apq_pkg::KIND_REMOVE, '0, '0);
    send_command(KIND_NOP, 32'sh8000_0000, 16'h0000);           // no-op with entries held
    send_command(apq_pkg::KIND_REMOVE, '0, '0);                 // last entry, no shift
    send_command(apq_pkg::KIND_REMOVE, '0, '0);
    send_command(apq_pkg::KIND_REMOVE, '0, '0);
    send_command(apq_pkg::KIND_REMOVE, '0, '0);                 // underflow again
    send_command(apq_pkg::KIND_PEEK, '0, '0);

    // random phases with different sender idling, each starting from a
    // quiet block
    drain_next = 1'b1;
    run_random(170, 1'b1);
    idle_pct = 69;
    drain_next = 1'b1;
    run_random(170, 1'b0);
    idle_pct = 0;
    drain_next = 1'b1;
    run_random(170, 1'b0);

    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
